### rtl/shfp_pkg.sv
// Shared types and codes for the sync header frame parser.
// No dependencies; imported by shfp_step and the top level.
`default_nettype none

package shfp_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 5;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 3;
   localparam int PHASE_W  = 2;
   localparam int COUNT_W  = 4;
   localparam int TABLE_W  = 40;
   localparam int SYNC_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 40;
   localparam int CODE_W   = 3;   // table holds eight commands

   // parse phases
   localparam logic [PHASE_W-1:0] PH_SYNC_HI = 2'd0;
   localparam logic [PHASE_W-1:0] PH_SYNC_LO = 2'd1;
   localparam logic [PHASE_W-1:0] PH_CMD     = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DATA    = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_HUNT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SYNC    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PAYLOAD = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ACCEPT  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_WORD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_TABLE   = 2'd2;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [LEN_W-1:0]   count;
      logic [LEN_W-1:0]   target;
      logic [BYTE_W-1:0]  command;
   } shfp_state_type;

   typedef struct packed {
      logic [SYNC_W-1:0]  sync_word;
      logic [COUNT_W-1:0] command_count;
      logic [TABLE_W-1:0] length_table;
   } shfp_cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   command;
      logic [BYTE_W-1:0]   payload_byte;
      logic [INDEX_W-1:0]  payload_index;
      logic                frame_done;
   } shfp_result_type;

endpackage

`default_nettype wire

### rtl/shfp_step.sv
// Per-byte parse logic: next parser state and the result for one byte.
// Depends on shfp_pkg.
`default_nettype none

module shfp_step #(
   parameter int MAX_COMMANDS = 8,
   parameter int MAX_PAYLOAD  = 16
) (
   input  wire  shfp_pkg::shfp_state_type  state_cur,
   input  wire  shfp_pkg::shfp_cfg_type    cfg,
   input  wire  logic [shfp_pkg::BYTE_W-1:0] rx_byte,
   output shfp_pkg::shfp_state_type        state_next,
   output shfp_pkg::shfp_result_type       result
);
   import shfp_pkg::*;

   localparam logic [COUNT_W-1:0] CMD_MAX = COUNT_W'(MAX_COMMANDS);
   localparam logic [LEN_W-1:0]   PAY_MAX = LEN_W'(MAX_PAYLOAD);

   logic [COUNT_W-1:0] cmd_limit;
   logic [LEN_W-1:0]   raw_len;
   logic [LEN_W-1:0]   cmd_len;
   logic [LEN_W-1:0]   count_inc;
   logic               cmd_ok;

   assign cmd_limit = (cfg.command_count > CMD_MAX) ? CMD_MAX : cfg.command_count;
   assign cmd_ok    = rx_byte < {{(BYTE_W-COUNT_W){1'b0}}, cmd_limit};
   assign raw_len   = cfg.length_table[LEN_W*rx_byte[CODE_W-1:0] +: LEN_W];
   assign cmd_len   = (raw_len > PAY_MAX) ? PAY_MAX : raw_len;
   assign count_inc = state_cur.count + LEN_W'(1);

   always_comb begin
      state_next           = state_cur;
      result.status        = ST_HUNT;
      result.payload_byte  = '0;
      result.payload_index = '0;
      result.frame_done    = 1'b0;
      case (state_cur.phase)
         PH_SYNC_HI: begin
            if (rx_byte == cfg.sync_word[SYNC_W-1:BYTE_W]) begin
               state_next.phase = PH_SYNC_LO;
            end
         end
         PH_SYNC_LO: begin
            if (rx_byte == cfg.sync_word[BYTE_W-1:0]) begin
               state_next.phase = PH_CMD;
               result.status    = ST_SYNC;
            end else begin
               state_next.phase = PH_SYNC_HI;
            end
         end
         PH_CMD: begin
            state_next.command = rx_byte;
            if (cmd_ok) begin
               result.status     = ST_ACCEPT;
               state_next.target = cmd_len;
               state_next.count  = '0;
               if (cmd_len == '0) begin
                  // empty payload: frame ends on the command byte
                  result.frame_done = 1'b1;
                  state_next.phase  = PH_SYNC_HI;
               end else begin
                  state_next.phase = PH_DATA;
               end
            end else begin
               result.status    = ST_REJECT;
               state_next.phase = PH_SYNC_HI;
            end
         end
         PH_DATA: begin
            result.status        = ST_PAYLOAD;
            result.payload_byte  = rx_byte;
            result.payload_index = state_cur.count[INDEX_W-1:0];
            state_next.count     = count_inc;
            if (count_inc >= state_cur.target) begin
               result.frame_done = 1'b1;
               state_next.phase  = PH_SYNC_HI;
            end
         end
         default: begin
            state_next.phase = PH_SYNC_HI;
         end
      endcase
      result.command = state_next.command;
   end

endmodule

`default_nettype wire

### rtl/sync_header_frame_parser_unit.sv
// Sync header frame parser: a request byte passes through the input register,
// then the result register, before its response is offered.
// Throughput is one byte per cycle while rsp_ready holds; the parse step is
// combinational and the phase/count registers update on each advance.
// Reset (synchronous, active high) clears the config registers, the parser
// state and both valid flags; no clearing pass is needed.
// Top level; depends on shfp_pkg and shfp_step.
`default_nettype none

module sync_header_frame_parser_unit #(
   parameter int MAX_COMMANDS = 8,
   parameter int MAX_PAYLOAD  = 16
) (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   // request channel
   input  wire  logic                                req_valid,
   output logic                                      req_ready,
   input  wire  logic [shfp_pkg::BYTE_W-1:0]         req_rx_byte,
   // response channel
   output logic                                      rsp_valid,
   input  wire  logic                                rsp_ready,
   output logic [shfp_pkg::STATUS_W-1:0]             rsp_status,
   output logic [shfp_pkg::BYTE_W-1:0]               rsp_command,
   output logic [shfp_pkg::BYTE_W-1:0]               rsp_payload_byte,
   output logic [shfp_pkg::INDEX_W-1:0]              rsp_payload_index,
   output logic                                      rsp_frame_done,
   // configuration write port
   input  wire  logic                                csr_write_enable,
   input  wire  logic [shfp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  logic [shfp_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import shfp_pkg::*;

   // config registers
   shfp_cfg_type cfg_ff;

   // input stage
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // parser state
   shfp_state_type state_ff;
   shfp_state_type state_in;

   // result stage
   logic            out_valid_ff;
   shfp_result_type out_ff;
   shfp_result_type out_in;

   logic advance;

   // input byte moves to the result register when that slot is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_WORD: cfg_ff.sync_word     <= csr_write_data[SYNC_W-1:0];
            CSR_CMD_COUNT: cfg_ff.command_count <= csr_write_data[COUNT_W-1:0];
            CSR_LEN_TABLE: cfg_ff.length_table  <= csr_write_data[TABLE_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   shfp_step #(
      .MAX_COMMANDS (MAX_COMMANDS),
      .MAX_PAYLOAD  (MAX_PAYLOAD)
   ) u_step (
      .state_cur  (state_ff),
      .cfg        (cfg_ff),
      .rx_byte    (in_byte_ff),
      .state_next (state_in),
      .result     (out_in)
   );

   // parser state only moves when the byte is handed to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_SYNC_HI, count: '0, target: '0, command: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_command       = out_ff.command;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_index = out_ff.payload_index;
   assign rsp_frame_done    = out_ff.frame_done;

   // frame end only on a payload byte or an empty accepted command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_status == ST_PAYLOAD || rsp_status == ST_ACCEPT))
      else $error("frame_done with wrong status");

   // payload fields are zero outside payload transfers
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_PAYLOAD) |->
         (rsp_payload_byte == '0 && rsp_payload_index == '0))
      else $error("payload fields set outside payload");

   // data phase is only entered with a nonzero target
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_DATA) |-> (state_ff.target != '0))
      else $error("data phase with zero length");

   // the parser state holds while no byte advances
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("parser state moved without a byte");

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sync_header_frame_parser_unit: streams link bytes,
// predicts each response in the bench and checks every response transfer.
// Depends on shfp_pkg and the parser RTL; nothing else.

module tb;
   import shfp_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int CMD_LIMIT_MAX = 8;      // command count saturates here
   localparam int LEN_SATURATE  = 16;     // table lengths saturate here
   localparam int SETTLE_CYCLES = 8;      // drain margin after the last response
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_BYTES  = 1600;
   localparam int CONFIG_PHASES = 8;

   // ---------------------------------------------------------------
   // DUT interface; every input holds a known value from time zero
   // ---------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [BYTE_W-1:0]     rsp_command;
   logic [BYTE_W-1:0]     rsp_payload_byte;
   logic [INDEX_W-1:0]    rsp_payload_index;
   logic                  rsp_frame_done;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SYNC_WORD;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   sync_header_frame_parser_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_command       (rsp_command),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_done    (rsp_frame_done),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------
   // Bench copy of the parser: register shadows and parse state.
   // Initial values match what reset leaves in the block.
   // ---------------------------------------------------------------
   logic [SYNC_W-1:0]  cfg_sync_word = '0;
   logic [COUNT_W-1:0] cfg_command_count = '0;
   logic [TABLE_W-1:0] cfg_length_table = '0;

   logic [PHASE_W-1:0] parse_phase = PH_SYNC_HI;
   logic [LEN_W-1:0]   payload_count = '0;
   logic [LEN_W-1:0]   payload_target = '0;
   logic [BYTE_W-1:0]  current_command = '0;

   // predicted responses, oldest first
   shfp_result_type    frame_results_q[$];

   int mismatch_count = 0;
   int bytes_sent = 0;
   int frames_done = 0;
   int sync_hits = 0;
   int rejects = 0;
   int payload_bytes = 0;
   int config_loads = 0;
   int burst_left = 0;
   int cycle_count = 0;
   logic [15:0] ready_pattern = 16'hFFFF;

   // codes at or above this count are rejected
   function automatic int command_limit();
      return (cfg_command_count > CMD_LIMIT_MAX) ? CMD_LIMIT_MAX : int'(cfg_command_count);
   endfunction

   function automatic logic [LEN_W-1:0] payload_length(input logic [BYTE_W-1:0] code);
      logic [LEN_W-1:0] len;
      if (code >= CMD_LIMIT_MAX) return '0;
      len = cfg_length_table[code[CODE_W-1:0] * LEN_W +: LEN_W];
      return (len > LEN_SATURATE) ? LEN_W'(LEN_SATURATE) : len;
   endfunction

   // Advance the bench parser by one byte and return the response it owes.
   function automatic shfp_result_type predict_frame_byte(input logic [BYTE_W-1:0] rx);
      shfp_result_type res;
      res = '0;
      res.status = ST_HUNT;
      case (parse_phase)
         PH_SYNC_HI: begin
            // a match only arms the second byte; status stays hunting
            if (rx == cfg_sync_word[15:8]) parse_phase = PH_SYNC_LO;
         end
         PH_SYNC_LO: begin
            // on a miss the byte is dropped, not retried as a first byte
            if (rx == cfg_sync_word[7:0]) begin
               parse_phase = PH_CMD;
               res.status = ST_SYNC;
            end else begin
               parse_phase = PH_SYNC_HI;
            end
         end
         PH_CMD: begin
            // command register takes the byte even when it is rejected
            current_command = rx;
            if (rx < command_limit()) begin
               res.status = ST_ACCEPT;
               payload_target = payload_length(rx);
               payload_count = '0;
               if (payload_target == 0) begin
                  res.frame_done = 1'b1;
                  parse_phase = PH_SYNC_HI;
               end else begin
                  parse_phase = PH_DATA;
               end
            end else begin
               res.status = ST_REJECT;
               parse_phase = PH_SYNC_HI;
            end
         end
         default: begin
            res.status = ST_PAYLOAD;
            res.payload_byte = rx;
            res.payload_index = payload_count[INDEX_W-1:0];
            payload_count = payload_count + 1'b1;
            if (payload_count >= payload_target) begin
               res.frame_done = 1'b1;
               parse_phase = PH_SYNC_HI;
            end
         end
      endcase
      res.command = current_command;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Request side. Called at a rising edge; returns at the edge of the
   // transfer (or after the gap that follows a burst). Valid stays up
   // between back-to-back bytes of a burst.
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      int gap;
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frame_results_q.push_back(predict_frame_byte(rx));
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Hold off until every predicted response has come back, then let the
   // pipeline drain. Registers are only touched after this.
   task automatic wait_parser_idle();
      req_valid <= 1'b0;
      while (frame_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SYNC_WORD: cfg_sync_word = data[SYNC_W-1:0];
         CSR_CMD_COUNT: cfg_command_count = data[COUNT_W-1:0];
         CSR_LEN_TABLE: cfg_length_table = data[TABLE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [SYNC_W-1:0] sync,
                              input logic [COUNT_W-1:0] count,
                              input logic [TABLE_W-1:0] lengths);
      wait_parser_idle();
      write_register(CSR_SYNC_WORD, CSR_DATA_W'(sync));
      write_register(CSR_CMD_COUNT, CSR_DATA_W'(count));
      write_register(CSR_LEN_TABLE, CSR_DATA_W'(lengths));
      config_loads++;
   endtask

   // mostly short payloads, some at or past saturation
   function automatic logic [TABLE_W-1:0] random_length_table();
      logic [TABLE_W-1:0] lengths;
      lengths = '0;
      for (int k = 0; k < CMD_LIMIT_MAX; k++)
         lengths[k * LEN_W +: LEN_W] = ($urandom_range(0, 5) == 0) ? LEN_W'($urandom_range(7, 31))
                                                                    : LEN_W'($urandom_range(0, 6));
      return lengths;
   endfunction

   // One random stretch of link traffic: mostly whole frames with random
   // content, else a broken header or plain line noise.
   task automatic send_frame_sequence();
      int pick;
      int n;
      logic [BYTE_W-1:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         code = (command_limit() > 0 && $urandom_range(0, 4) != 0)
                ? BYTE_W'($urandom_range(0, command_limit() - 1)) : BYTE_W'($urandom);
         send_byte(cfg_sync_word[15:8]);
         send_byte(cfg_sync_word[7:0]);
         send_byte(code);
         if (code < command_limit()) begin
            n = int'(payload_length(code));
            repeat (n) send_byte(BYTE_W'($urandom));
         end
      end else if (pick < 88) begin
         // header cut short or corrupted after the first sync byte
         send_byte(cfg_sync_word[15:8]);
         send_byte(BYTE_W'($urandom));
         if ($urandom_range(0, 1) == 1) send_byte(BYTE_W'($urandom));
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reset registers: sync word zero, no valid commands.
   task automatic test_reset_defaults();
      send_byte(8'h00);
      send_byte(8'h00);   // sync accepted
      send_byte(8'h00);   // command 0 rejected, count is zero
      send_byte(8'h5A);
   endtask

   // Second byte miss drops the byte; code equal to the count is rejected.
   task automatic test_sync_hunt();
      load_config(16'h1234, 4'd8, random_length_table());
      send_byte(8'h12);
      send_byte(8'h12);   // miss on second byte, not rearmed
      send_byte(8'h34);   // still hunting
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h08);   // at the count: rejected
   endtask

   // All-ones sync, oversized count, zero and one byte payloads.
   task automatic test_command_decode();
      load_config(16'hFFFF, 4'd15, {{30{1'b1}}, 5'd1, 5'd0});
      send_byte(8'hFF);
      send_byte(8'h00);   // miss on second byte
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);   // zero length: done at once
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'hFF);   // single payload byte, done
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);   // code past the clamp: rejected
   endtask

   // Random traffic across several register settings, extremes first.
   task automatic test_random_frames();
      int start;
      logic [BYTE_W-1:0] repeated;
      for (int p = 0; p < CONFIG_PHASES; p++) begin
         repeated = BYTE_W'($urandom);
         case (p)
            0: load_config('0, 4'd8, {TABLE_W{1'b1}});   // every length saturates
            1: load_config('1, 4'd15, random_length_table());
            2: load_config(SYNC_W'($urandom), 4'd0, random_length_table());
            3: load_config({repeated, repeated}, 4'd4, random_length_table());
            default: load_config(SYNC_W'($urandom), COUNT_W'($urandom_range(1, 15)),
                                 random_length_table());
         endcase
         start = bytes_sent;
         while (bytes_sent - start < RANDOM_BYTES / CONFIG_PHASES) send_frame_sequence();
      end
   endtask

   // ---------------------------------------------------------------
   // Response side: check each transfer, then drive the stall pattern.
   // Values read here are the ones from before the edge.
   // ---------------------------------------------------------------
   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      shfp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_results_q.size() == 0) begin
            $display("%0t: response transfer with nothing outstanding, status %0d",
                     $time, rsp_status);
            mismatch_count++;
         end else begin
            want = frame_results_q.pop_front();
            compare_field("status", 8'(want.status), 8'(rsp_status));
            compare_field("command", want.command, rsp_command);
            compare_field("payload_byte", want.payload_byte, rsp_payload_byte);
            compare_field("payload_index", 8'(want.payload_index), 8'(rsp_payload_index));
            compare_field("frame_done", 8'(want.frame_done), 8'(rsp_frame_done));
            if (want.frame_done) frames_done++;
            if (want.status == ST_SYNC) sync_hits++;
            if (want.status == ST_REJECT) rejects++;
            if (want.status == ST_PAYLOAD) payload_bytes++;
         end
      end
      // pick a new stall pattern (open, random, sparse, alternating), else rotate it
      if (cycle_count % 128 == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pattern <= 16'hFFFF;
            1: ready_pattern <= 16'($urandom) | 16'h0100;
            2: ready_pattern <= 16'h0001;
            default: ready_pattern <= 16'hCCCC;
         endcase
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
      rsp_ready <= ready_pattern[0];
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, frame_results_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_sync_hunt();
      test_command_decode();
      test_random_frames();

      wait_parser_idle();
      $display("%0d bytes over %0d register settings: %0d syncs, %0d frames done",
               bytes_sent, config_loads, sync_hits, frames_done);
      $display("%0d payload bytes, %0d rejected commands, %0d mismatches",
               payload_bytes, rejects, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
